// File: design/maximal_matching_check_assert.svh
// assertion macros for the maximal matching checker
// used by the top level only; no other dependencies
`ifndef MAXIMAL_MATCHING_CHECK_ASSERT_SVH
`define MAXIMAL_MATCHING_CHECK_ASSERT_SVH

`ifndef SYNTHESIS
`define MMC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("maximal_matching_check assertion failed");
`define MMC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("maximal_matching_check assertion failed");
`else
`define MMC_ASSERT_NOW(label, ante, cons)
`define MMC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/mmc_pkg.sv
// shared constants for the maximal matching checker
// no dependencies
`timescale 1ns / 1ps

package mmc_pkg;

   localparam int ACTION_WIDTH  = 2;
   localparam int VERTEX_WIDTH  = 8;
   localparam int VERDICT_WIDTH = 2;

   localparam logic [ACTION_WIDTH-1:0] ACT_ADD_EDGE   = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_BEGIN      = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_QUERY_EDGE = 2'd2;
   localparam logic [ACTION_WIDTH-1:0] ACT_FINISH     = 2'd3;

   localparam logic [VERDICT_WIDTH-1:0] VERD_NOT_MATCHING = 2'd0;
   localparam logic [VERDICT_WIDTH-1:0] VERD_MAXIMAL      = 2'd1;
   localparam logic [VERDICT_WIDTH-1:0] VERD_NOT_MAXIMAL  = 2'd2;

   localparam logic [VERTEX_WIDTH-1:0] NUM_VERTICES_RESET = 8'd255;

endpackage

// File: design/mmc_req_if.sv
// request channel: action and edge endpoints
// depends on mmc_pkg
`timescale 1ns / 1ps

interface mmc_req_if;
   logic                                valid;
   logic                                ready;
   logic [mmc_pkg::ACTION_WIDTH-1:0]    action;
   logic [mmc_pkg::VERTEX_WIDTH-1:0]    vertex_u;
   logic [mmc_pkg::VERTEX_WIDTH-1:0]    vertex_v;

   modport source (output valid, output action, output vertex_u, output vertex_v, input ready);
   modport sink   (input valid, input action, input vertex_u, input vertex_v, output ready);
endinterface

// File: design/mmc_rsp_if.sv
// response channel: query verdict
// depends on mmc_pkg
`timescale 1ns / 1ps

interface mmc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mmc_pkg::VERDICT_WIDTH-1:0]   verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

// File: design/mmc_csr_if.sv
// configuration write channel: vertex count
// depends on mmc_pkg
`timescale 1ns / 1ps

interface mmc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mmc_pkg::VERTEX_WIDTH-1:0]    num_vertices;

   modport source (output valid, output num_vertices, input ready);
   modport sink   (input valid, input num_vertices, output ready);
endinterface

// File: design/mmc_adj_ram.sv
// adjacency row memory, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module mmc_adj_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: design/mmc_row_check.sv
// row compare unit: finds a graph edge from an unused vertex to a later unused vertex
// no dependencies
`timescale 1ns / 1ps

module mmc_row_check #(
   parameter int WIDTH = 256
) (
   input  logic [WIDTH-1:0] row,
   input  logic [WIDTH-1:0] used,
   input  logic [WIDTH-1:0] in_range,
   input  logic [WIDTH-1:0] above,
   input  logic             row_used,
   output logic             hit
);

   assign hit = !row_used && (|(row & ~used & in_range & above));

endmodule

// File: design/maximal_matching_check.sv
// maximal matching checker top level: graph store, query marks and scan sequencer
// depends on mmc_pkg, the mmc_*_if interfaces, mmc_adj_ram and mmc_row_check
// add graph edge: row read, then row write; begin and query edge: done when accepted
// finish: accept then result load when not a matching or under two vertices in range, else
//   accept, one adjacency row per cycle from the ram, result load
// after reset every ram row is swept to zero in turn with no item taken
`timescale 1ns / 1ps

`include "maximal_matching_check_assert.svh"

module maximal_matching_check #(
   parameter int MAX_VERTICES = 256
) (
   input  logic      clock,
   input  logic      reset,
   mmc_req_if.sink   req_ch,
   mmc_rsp_if.source rsp_ch,
   mmc_csr_if.sink   csr_ch
);

   localparam int VW = $clog2(MAX_VERTICES);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_WR,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type                            state_ff, state_in;
   logic [VW-1:0]                        clr_row_ff, clr_row_in;
   logic [mmc_pkg::VERTEX_WIDTH-1:0]     nv_ff, nv_in;
   logic [MAX_VERTICES-1:0]              used_ff, used_in;
   logic                                 match_ff, match_in;
   logic [VW-1:0]                        add_row_ff, add_row_in;
   logic [VW-1:0]                        add_col_ff, add_col_in;
   logic [VW-1:0]                        rd_row_ff, rd_row_in;
   logic [VW-1:0]                        ev_row_ff, ev_row_in;
   logic                                 ev_vld_ff, ev_vld_in;
   logic [VW-1:0]                        lim_ff, lim_in;
   logic [MAX_VERTICES-1:0]              above_ff, above_in;
   logic [mmc_pkg::VERDICT_WIDTH-1:0]    pend_ff, pend_in;
   logic                                 rsp_vld_ff, rsp_vld_in;
   logic [mmc_pkg::VERDICT_WIDTH-1:0]    rsp_verdict_ff, rsp_verdict_in;

   logic                    accept;
   logic [VW-1:0]           u_idx, v_idx, lo_idx, hi_idx, nv_lim;
   logic                    u_ok, v_ok, edge_ok;
   logic [MAX_VERTICES-1:0] in_range;
   logic                    ram_we;
   logic [VW-1:0]           ram_waddr, ram_raddr;
   logic [MAX_VERTICES-1:0] ram_wdata, ram_rdata;
   logic                    row_hit;

   assign req_ch.ready  = (state_ff == ST_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign rsp_ch.valid  = rsp_vld_ff;
   assign rsp_ch.verdict = rsp_verdict_ff;

   assign accept = req_ch.valid && req_ch.ready;

   assign u_idx   = VW'(req_ch.vertex_u);
   assign v_idx   = VW'(req_ch.vertex_v);
   assign u_ok    = (req_ch.vertex_u != '0) && (req_ch.vertex_u <= nv_ff)
                    && (int'(req_ch.vertex_u) < MAX_VERTICES);
   assign v_ok    = (req_ch.vertex_v != '0) && (req_ch.vertex_v <= nv_ff)
                    && (int'(req_ch.vertex_v) < MAX_VERTICES);
   assign edge_ok = u_ok && v_ok;
   assign lo_idx  = (u_idx < v_idx) ? u_idx : v_idx;
   assign hi_idx  = (u_idx < v_idx) ? v_idx : u_idx;
   assign nv_lim  = (int'(nv_ff) < MAX_VERTICES) ? VW'(nv_ff) : VW'(MAX_VERTICES - 1);

   // vertices 1..lim of the running scan
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         in_range[i] = (i != 0) && (i <= int'(lim_ff));
      end
   end

   // only the upper triangle (row < column) is stored, which is all the scan reads
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = add_row_ff;
      ram_wdata = ram_rdata | (MAX_VERTICES'(1) << add_col_ff);
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_row_ff;
         ram_wdata = '0;
      end else if (state_ff == ST_ADD_WR) begin
         ram_we = 1'b1;
      end
   end

   assign ram_raddr = (state_ff == ST_SCAN) ? rd_row_ff : lo_idx;

   mmc_adj_ram #(
      .DEPTH (MAX_VERTICES),
      .WIDTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   mmc_row_check #(
      .WIDTH (MAX_VERTICES)
   ) u_row_check (
      .row      (ram_rdata),
      .used     (used_ff),
      .in_range (in_range),
      .above    (above_ff),
      .row_used (used_ff[ev_row_ff]),
      .hit      (row_hit)
   );

   always_comb begin
      state_in       = state_ff;
      clr_row_in     = clr_row_ff;
      nv_in          = nv_ff;
      used_in        = used_ff;
      match_in       = match_ff;
      add_row_in     = add_row_ff;
      add_col_in     = add_col_ff;
      rd_row_in      = rd_row_ff;
      ev_row_in      = ev_row_ff;
      ev_vld_in      = ev_vld_ff;
      lim_in         = lim_ff;
      above_in       = above_ff;
      pend_in        = pend_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_ch.ready;
      rsp_verdict_in = rsp_verdict_ff;

      if (csr_ch.valid) begin
         nv_in = csr_ch.num_vertices;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + 1'b1;
            if (clr_row_ff == VW'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_ch.action)
                  mmc_pkg::ACT_ADD_EDGE: begin
                     // self loops never count in the scan, so they are not stored
                     if (edge_ok && (u_idx != v_idx)) begin
                        add_row_in = lo_idx;
                        add_col_in = hi_idx;
                        state_in   = ST_ADD_WR;
                     end
                  end
                  mmc_pkg::ACT_BEGIN: begin
                     used_in  = '0;
                     match_in = 1'b1;
                  end
                  mmc_pkg::ACT_QUERY_EDGE: begin
                     if (edge_ok) begin
                        if (used_ff[u_idx] || used_ff[v_idx]) begin
                           match_in = 1'b0;
                        end
                        used_in[u_idx] = 1'b1;
                        used_in[v_idx] = 1'b1;
                     end
                  end
                  mmc_pkg::ACT_FINISH: begin
                     lim_in = nv_lim;
                     if (!match_ff) begin
                        pend_in  = mmc_pkg::VERD_NOT_MATCHING;
                        state_in = ST_DONE;
                     end else if (nv_lim < VW'(2)) begin
                        pend_in  = mmc_pkg::VERD_MAXIMAL;
                        state_in = ST_DONE;
                     end else begin
                        rd_row_in = VW'(1);
                        ev_vld_in = 1'b0;
                        above_in  = {MAX_VERTICES{1'b1}} << 2;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD_WR: begin
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // read of row n is in flight while row n-1 is checked
            rd_row_in = rd_row_ff + 1'b1;
            ev_row_in = rd_row_ff;
            ev_vld_in = 1'b1;
            if (ev_vld_ff) begin
               above_in = above_ff << 1;
               if (row_hit) begin
                  pend_in  = mmc_pkg::VERD_NOT_MAXIMAL;
                  state_in = ST_DONE;
               end else if (ev_row_ff == lim_ff - 1'b1) begin
                  pend_in  = mmc_pkg::VERD_MAXIMAL;
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               rsp_vld_in     = 1'b1;
               rsp_verdict_in = pend_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_row_ff <= '0;
         nv_ff      <= mmc_pkg::NUM_VERTICES_RESET;
         used_ff    <= '0;
         match_ff   <= 1'b1;
         ev_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
         nv_ff      <= nv_in;
         used_ff    <= used_in;
         match_ff   <= match_in;
         ev_vld_ff  <= ev_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      add_row_ff     <= add_row_in;
      add_col_ff     <= add_col_in;
      rd_row_ff      <= rd_row_in;
      ev_row_ff      <= ev_row_in;
      lim_ff         <= lim_in;
      above_ff       <= above_in;
      pend_ff        <= pend_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   `MMC_ASSERT_NEXT(a_finish_not_matching,
      accept && (req_ch.action == mmc_pkg::ACT_FINISH) && !match_ff,
      (state_ff == ST_DONE) && (pend_ff == mmc_pkg::VERD_NOT_MATCHING))
   `MMC_ASSERT_NOW(a_scan_row_in_range, (state_ff == ST_SCAN) && ev_vld_ff,
      (ev_row_ff != '0) && (ev_row_ff < lim_ff))
   `MMC_ASSERT_NOW(a_rsp_from_done, $rose(rsp_vld_ff), $past(state_ff == ST_DONE))
   `MMC_ASSERT_NEXT(a_reuse_drops_match,
      accept && (req_ch.action == mmc_pkg::ACT_QUERY_EDGE) && edge_ok
         && (used_ff[u_idx] || used_ff[v_idx]),
      !match_ff)

endmodule
